>>> rtl/core/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types and constants for the linear interpolation unit.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned PROD_W  = 65;
  localparam int unsigned DIV_STEPS = 65;
  localparam int unsigned CNT_W   = 7;

  localparam logic [1:0] CFG_ENTRY_COUNT = 2'd0;
  localparam logic [1:0] CFG_FILL_VALUE  = 2'd1;
  localparam logic [1:0] CFG_TABLE_READY = 2'd2;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]  t;
    logic [VALUE_W-1:0] x;
    logic               v;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    RES_FILL_ZERO,
    RES_FILL_IDX,
    RES_X0,
    RES_SUM
  } res_sel_t;

  typedef struct packed {
    logic     cap_q;
    logic     load_lo;
    logic     load_hi;
    logic     shift_fwd;
    logic     shift_bwd;
    logic     prep;
    logic     mul;
    logic     div_step;
    logic     res_load;
    res_sel_t res_sel;
    logic     rd_en;
  } cmd_t;

  typedef struct packed {
    logic q_lt_lo;
    logic q_gt_rd;
    logic match;
    logic ge;
    logic both_valid;
    logic t_equal;
    logic out_full;
  } status_t;

endpackage

>>> rtl/core/tli_ram.sv
// ----------------------------------------------------------------------------
// tli_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tli_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/tli_datapath.sv
// ----------------------------------------------------------------------------
// tli_datapath
// Bracket entry registers, multiply, restoring divide and result register.
// ----------------------------------------------------------------------------
module tli_datapath import tli_pkg::*; #(
  parameter int unsigned AW = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             st,
  input  logic [TIME_W-1:0]   query_time,
  input  entry_t              rd,
  input  logic [VALUE_W-1:0]  fill_value,
  input  logic [AW-1:0]       idx,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  interp_value,
  output logic                used_fill,
  output logic [9:0]          bracket_index
);

  localparam int unsigned IW = (AW + 1 > 10) ? AW + 1 : 10;

  logic [TIME_W-1:0] q;
  entry_t            lo;
  entry_t            hi;
  logic [31:0]       adq;
  logic [32:0]       adx;
  logic [31:0]       adt;
  logic              neg;
  logic [PROD_W-1:0] dvd;
  logic [31:0]       rem;

  logic signed [32:0] dx;
  logic [32:0]        r2;
  logic               qbit;
  logic [33:0]        quot;
  logic signed [35:0] sum;
  logic signed [31:0] sum_sat;
  logic [IW-1:0]      idx_ext;

  always_comb begin
    st.q_lt_lo    = q < lo.t;
    st.q_gt_rd    = q > rd.t;
    st.ge         = q >= lo.t;
    st.match      = (q >= lo.t) && (q < hi.t);
    st.both_valid = lo.v && hi.v;
    st.t_equal    = lo.t == hi.t;
    st.out_full   = out_valid && !out_ready;
  end

  assign dx = $signed({hi.x[31], hi.x}) - $signed({lo.x[31], lo.x});
  assign r2 = {rem, dvd[PROD_W-1]};
  assign qbit = r2 >= {1'b0, adt};

  always_comb begin
    if (dvd > 65'h200000000) begin
      quot = 34'h200000000;
    end else begin
      quot = dvd[33:0];
    end
    if (neg) begin
      sum = $signed({{4{lo.x[31]}}, lo.x}) - $signed({2'b00, quot});
    end else begin
      sum = $signed({{4{lo.x[31]}}, lo.x}) + $signed({2'b00, quot});
    end
    if (sum > 36'sd2147483647) begin
      sum_sat = 32'sh7fffffff;
    end else if (sum < -36'sd2147483648) begin
      sum_sat = 32'sh80000000;
    end else begin
      sum_sat = sum[31:0];
    end
  end

  assign idx_ext = IW'(idx);

  always_ff @(posedge clk) begin
    if (cmd.cap_q) begin
      q <= query_time;
    end
    if (cmd.load_lo) begin
      lo <= rd;
    end
    if (cmd.load_hi) begin
      hi <= rd;
    end
    if (cmd.shift_fwd) begin
      lo <= hi;
      hi <= rd;
    end
    if (cmd.shift_bwd) begin
      hi <= lo;
      lo <= rd;
    end
    if (cmd.prep) begin
      adq <= (q >= lo.t) ? q - lo.t : lo.t - q;
      adx <= dx[32] ? 33'(-dx) : 33'(dx);
      adt <= (hi.t > lo.t) ? hi.t - lo.t : lo.t - hi.t;
      neg <= (q < lo.t) ^ dx[32] ^ (hi.t < lo.t);
    end
    if (cmd.mul) begin
      dvd <= PROD_W'(64'(adq * adx));
      rem <= '0;
    end
    if (cmd.div_step) begin
      rem <= qbit ? 32'(r2 - {1'b0, adt}) : r2[31:0];
      dvd <= {dvd[PROD_W-2:0], qbit};
    end
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_FILL_ZERO: begin
          interp_value  <= fill_value;
          used_fill     <= 1'b1;
          bracket_index <= '0;
        end
        RES_FILL_IDX: begin
          interp_value  <= fill_value;
          used_fill     <= 1'b1;
          bracket_index <= idx_ext[9:0];
        end
        RES_X0: begin
          interp_value  <= lo.x;
          used_fill     <= 1'b0;
          bracket_index <= idx_ext[9:0];
        end
        default: begin
          interp_value  <= sum_sat;
          used_fill     <= 1'b0;
          bracket_index <= idx_ext[9:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/core/tli_ctrl.sv
// ----------------------------------------------------------------------------
// tli_ctrl
// Query sequencer: range check, bracket search from the cursor, divide count.
// ----------------------------------------------------------------------------
module tli_ctrl import tli_pkg::*; #(
  parameter int unsigned AW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          action,
  input  logic          table_ready,
  input  logic [AW:0]   n,
  input  status_t       st,
  output cmd_t          cmd,
  output logic [AW-1:0] rd_addr,
  output logic [AW-1:0] idx
);

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_RD_FIRST, S_RD_LAST, S_RD_S0, S_RD_S1, S_CHECK0,
    S_FWD_WAIT, S_FWD_CHK, S_BWD_WAIT, S_BWD_CHK, S_EVAL, S_MUL, S_DIV, S_SUM
  } state_t;

  state_t           state, state_next;
  logic [AW-1:0]    cursor, cursor_next;
  logic [AW-1:0]    i_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [AW:0]      n_m1;
  logic [AW:0]      n_m2;
  logic [AW-1:0]    start;

  assign n_m1  = n - 1'b1;
  assign n_m2  = n - 2'd2;
  assign start = ({1'b0, cursor} < n_m1) ? cursor : '0;
  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd         = '0;
    rd_addr     = '0;
    state_next  = state;
    cursor_next = cursor;
    i_next      = idx;
    cnt_next    = cnt;
    case (state)
      S_IDLE: begin
        if (in_valid && action == ACT_QUERY) begin
          cmd.cap_q = 1'b1;
          if (!table_ready || n < 2) begin
            state_next = S_FILL;
          end else begin
            cmd.rd_en  = 1'b1;
            state_next = S_RD_FIRST;
          end
        end
      end
      S_FILL: begin
        if (!st.out_full) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_FILL_ZERO;
          cursor_next  = '0;
          state_next   = S_IDLE;
        end
      end
      S_RD_FIRST: begin
        cmd.load_lo = 1'b1;
        cmd.rd_en   = 1'b1;
        rd_addr     = n_m1[AW-1:0];
        state_next  = S_RD_LAST;
      end
      S_RD_LAST: begin
        if (st.q_lt_lo || st.q_gt_rd) begin
          state_next = S_FILL;
        end else begin
          cmd.rd_en  = 1'b1;
          rd_addr    = start;
          i_next     = start;
          state_next = S_RD_S0;
        end
      end
      S_RD_S0: begin
        cmd.load_lo = 1'b1;
        cmd.rd_en   = 1'b1;
        rd_addr     = AW'(idx + 1'b1);
        state_next  = S_RD_S1;
      end
      S_RD_S1: begin
        cmd.load_hi = 1'b1;
        state_next  = S_CHECK0;
      end
      S_CHECK0, S_FWD_CHK, S_BWD_CHK: begin
        if (st.match) begin
          state_next = S_EVAL;
        end else if ((state == S_CHECK0 && st.ge) || state == S_FWD_CHK) begin
          if ({1'b0, idx} == n_m2) begin
            state_next = S_EVAL;
          end else begin
            cmd.rd_en  = 1'b1;
            rd_addr    = AW'(idx + 2'd2);
            i_next     = AW'(idx + 1'b1);
            state_next = S_FWD_WAIT;
          end
        end else begin
          if (idx == '0) begin
            state_next = S_EVAL;
          end else begin
            cmd.rd_en  = 1'b1;
            rd_addr    = AW'(idx - 1'b1);
            i_next     = AW'(idx - 1'b1);
            state_next = S_BWD_WAIT;
          end
        end
      end
      S_FWD_WAIT: begin
        cmd.shift_fwd = 1'b1;
        state_next    = S_FWD_CHK;
      end
      S_BWD_WAIT: begin
        cmd.shift_bwd = 1'b1;
        state_next    = S_BWD_CHK;
      end
      S_EVAL: begin
        cursor_next = idx;
        if (!st.both_valid || st.t_equal) begin
          if (!st.out_full) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = st.both_valid ? RES_X0 : RES_FILL_IDX;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.prep   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = CNT_W'(cnt + 1'b1);
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        if (!st.out_full) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_SUM;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cursor <= '0;
      idx    <= '0;
      cnt    <= '0;
    end else begin
      state  <= state_next;
      cursor <= cursor_next;
      idx    <= i_next;
      cnt    <= cnt_next;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> !st.out_full)
    else $error("result written while output full");

  a_shift_after_read: assert property (@(posedge clk) disable iff (rst)
    (cmd.shift_fwd || cmd.shift_bwd) |-> $past(cmd.rd_en))
    else $error("bracket shift without a read");

  a_bracket_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> ({1'b0, idx} <= n_m2))
    else $error("bracket index beyond table");

endmodule

>>> rtl/core/time_series_linear_interp_unit.sv
// ----------------------------------------------------------------------------
// time_series_linear_interp_unit
// Piecewise linear interpolation over a time-sorted sample table.
// Load item: one table write. Query: fill value when the table is not ready or
//   the query is out of range; else a bracket search, then a bit-serial divide,
//   or fill / lower value when an endpoint is invalid / the times are equal.
// One item at a time; a waiting result holds the next query at its result step.
// Synchronous reset clears control state and the search cursor and resets the
// configuration registers; table contents are undefined until written.
// ----------------------------------------------------------------------------
module time_series_linear_interp_unit import tli_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic [9:0]         entry_index,
  input  logic [31:0]        sample_time,
  input  logic signed [31:0] sample_value,
  input  logic               sample_valid,
  input  logic [31:0]        query_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] interp_value,
  output logic               used_fill,
  output logic [9:0]         bracket_index,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = (AW + 1 > 11) ? AW + 1 : 11;
  localparam int unsigned IW = (AW + 1 > 10) ? AW + 1 : 10;

  logic [10:0]  entry_count;
  logic [31:0]  fill_value;
  logic         table_ready;

  logic [AW:0]   n;
  logic [CW-1:0] cnt_ext;
  logic [IW-1:0] widx_ext;
  logic          we;
  entry_t        wentry;
  entry_t        rd;
  logic [ENTRY_W-1:0] rdata;
  cmd_t          cmd;
  status_t       st;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= 11'd2;
      fill_value  <= '0;
      table_ready <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENTRY_COUNT: entry_count <= cfg_data[10:0];
        CFG_FILL_VALUE:  fill_value  <= cfg_data;
        CFG_TABLE_READY: table_ready <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cnt_ext  = CW'(entry_count);
  assign n        = (cnt_ext > CW'(DEPTH)) ? (AW+1)'(DEPTH) : (AW+1)'(cnt_ext);
  assign widx_ext = IW'(entry_index);
  assign we       = in_valid && in_ready && action == ACT_LOAD && widx_ext < IW'(DEPTH);

  assign wentry.t = sample_time;
  assign wentry.x = sample_value;
  assign wentry.v = sample_valid;
  assign rd       = rdata;

  tli_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(widx_ext[AW-1:0]),
    .wdata(wentry),
    .re   (cmd.rd_en),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  tli_ctrl #(
    .AW(AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .table_ready(table_ready),
    .n          (n),
    .st         (st),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .idx        (idx)
  );

  tli_datapath #(
    .AW(AW)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .query_time   (query_time),
    .rd           (rd),
    .fill_value   (fill_value),
    .idx          (idx),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .interp_value (interp_value),
    .used_fill    (used_fill),
    .bracket_index(bracket_index)
  );

endmodule
